// ----- src/fbde_pkg.sv -----
// ----------------------------------------------------------------------------
// fbde_pkg: shared types and constants of the frame store draw engine
// Command codes, field layout, controller/datapath interface structs and the
// 5x7 column-coded font.
// ----------------------------------------------------------------------------
package fbde_pkg;

  localparam int FRAME_WIDTH_DEF  = 128;
  localparam int FRAME_HEIGHT_DEF = 64;

  localparam int IN_DATA_W  = 64;  // 58 payload bits padded to bytes
  localparam int OUT_DATA_W = 16;  // 10 payload bits padded to bytes

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;

  localparam logic [3:0] MODE_PIXEL      = 4'd0;
  localparam logic [3:0] MODE_READ_PIXEL = 4'd1;
  localparam logic [3:0] MODE_FILL       = 4'd2;
  localparam logic [3:0] MODE_HLINE      = 4'd3;
  localparam logic [3:0] MODE_VLINE      = 4'd4;
  localparam logic [3:0] MODE_RECT       = 4'd5;
  localparam logic [3:0] MODE_GLYPH      = 4'd6;
  localparam logic [3:0] MODE_READ_BYTE  = 4'd7;
  localparam logic [3:0] MODE_CLR_DIRTY  = 4'd8;

  localparam logic [1:0] INK_SET  = 2'd1;
  localparam logic [1:0] INK_FLIP = 2'd2;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLR_WR,
    OP_FILL_RD,
    OP_FILL_WR,
    OP_SEG_SET,
    OP_GLYPH_INIT,
    OP_ADVANCE,
    OP_PIX_RD,
    OP_PIX_WR,
    OP_SAMPLE_PIX,
    OP_BYTE_RD,
    OP_SAMPLE_BYTE,
    OP_CLR_DIRTY,
    OP_RESULT
  } op_t;

  // line segment set up by OP_SEG_SET
  typedef enum logic [2:0] {
    SEG_DOT,
    SEG_HORZ,
    SEG_VERT,
    SEG_TOP,
    SEG_BOTTOM,
    SEG_LEFT,
    SEG_RIGHT
  } seg_t;

  typedef struct packed {
    op_t  op;
    seg_t seg;
  } cmd_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       more;        // walker has a position left
    logic       live;        // current position is drawn
    logic       box_ok;      // rectangle draws something
    logic       origin_ok;   // origin inside the frame
    logic       sweep_last;  // sweep at last store byte
  } status_t;

  localparam logic [39:0] DIGIT_FONT [10] = '{
    40'h3E_45_49_51_3E, 40'h00_40_7F_42_00, 40'h46_49_51_61_42, 40'h31_4B_45_41_21,
    40'h10_7F_12_14_18, 40'h39_45_45_45_27, 40'h30_49_49_4A_3C, 40'h03_05_09_71_01,
    40'h36_49_49_49_36, 40'h1E_29_49_49_06
  };

  localparam logic [39:0] LETTER_FONT [26] = '{
    40'h7E_11_11_11_7E, 40'h36_49_49_49_7F, 40'h22_41_41_41_3E, 40'h1C_22_41_41_7F,
    40'h41_49_49_49_7F, 40'h01_09_09_09_7F, 40'h7A_49_49_41_3E, 40'h7F_08_08_08_7F,
    40'h00_41_7F_41_00, 40'h01_3F_41_40_20, 40'h41_22_14_08_7F, 40'h40_40_40_40_7F,
    40'h7F_02_0C_02_7F, 40'h7F_10_08_04_7F, 40'h3E_41_41_41_3E, 40'h06_09_09_09_7F,
    40'h5E_21_51_41_3E, 40'h46_29_19_09_7F, 40'h31_49_49_49_46, 40'h01_01_7F_01_01,
    40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63,
    40'h07_08_70_08_07, 40'h43_45_49_51_61
  };

  localparam logic [39:0] FONT_QUERY  = 40'h06_09_51_01_02;
  localparam logic [39:0] FONT_MINUS  = 40'h08_08_08_08_08;
  localparam logic [39:0] FONT_PERIOD = 40'h00_00_60_60_00;
  localparam logic [39:0] FONT_COLON  = 40'h00_00_36_36_00;
  localparam logic [39:0] FONT_SLASH  = 40'h02_04_08_10_20;
  localparam logic [39:0] FONT_BLANK  = 40'h00_00_00_00_00;

  // one glyph column, LSB = top row; lowercase folds, unknown codes give '?'
  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
    logic [7:0]  c;
    logic [39:0] g;
    logic [3:0]  di;
    logic [4:0]  li;
    c  = code;
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
    di = 4'(c - 8'h30);
    li = 5'(c - 8'h41);
    if (c >= 8'h30 && c <= 8'h39)      g = DIGIT_FONT[di];
    else if (c >= 8'h41 && c <= 8'h5A) g = LETTER_FONT[li];
    else if (c == 8'h20)               g = FONT_BLANK;
    else if (c == 8'h2D)               g = FONT_MINUS;
    else if (c == 8'h2E)               g = FONT_PERIOD;
    else if (c == 8'h3A)               g = FONT_COLON;
    else if (c == 8'h2F)               g = FONT_SLASH;
    else                               g = FONT_QUERY;
    return 8'(g >> {col, 3'b000});
  endfunction

endpackage

// ----- src/fbde_ram.sv -----
// ----------------------------------------------------------------------------
// fbde_ram: generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module fbde_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/fbde_datapath.sv -----
// ----------------------------------------------------------------------------
// fbde_datapath: frame store, pixel walker and result registers
// Executes one controller operation per cycle: store sweeps, line and glyph
// position walking, pixel read-modify-write and result capture.
// ----------------------------------------------------------------------------
module fbde_datapath #(
  parameter int FRAME_WIDTH  = fbde_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = fbde_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [fbde_pkg::IN_DATA_W-1:0]     in_tdata,
  input  fbde_pkg::cmd_t                     cmd,
  output fbde_pkg::status_t                  status,
  output logic [fbde_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import fbde_pkg::*;

  localparam int PAGES       = (FRAME_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = FRAME_WIDTH * PAGES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam logic [9:0]    W10       = 10'(FRAME_WIDTH);
  localparam logic [9:0]    H10       = 10'(FRAME_HEIGHT);
  localparam logic [AW-1:0] SWEEP_END = AW'(STORE_BYTES - 1);

  // latched command item
  logic [3:0] mode_r;
  logic [7:0] x_r;
  logic [6:0] y_r;
  logic [7:0] run_r;
  logic [6:0] hgt_r;
  logic [1:0] ink_r;
  logic [7:0] code_r;
  logic [3:0] scale_r;
  logic [9:0] idx_r;

  // walker
  logic       glyph_r;
  logic       vert_r;
  logic [9:0] lx_r, ly_r;
  logic [7:0] cnt_r, len_r;
  logic [2:0] gc_r, gr_r;
  logic [3:0] sx_r, sy_r;
  logic [9:0] cb_r, rb_r;

  logic [AW-1:0] sweep_r;
  logic          dirty_r;
  logic          res_pix_r;
  logic [7:0]    res_byte_r;
  logic          out_pix_r;
  logic [7:0]    out_byte_r;
  logic          out_dirty_r;

  logic [3:0]    scl, scl_last;
  logic [7:0]    col_bits;
  logic          gbit;
  logic [9:0]    cur_x, cur_y, along, limit;
  logic          in_frame;
  logic [AW-1:0] pix_addr, ram_addr;
  logic [7:0]    mask, pix_wdata, fill_wdata, ram_wdata, rdata;
  logic          ram_we;
  logic [9:0]    wlim, hlim, wc, hc;
  logic          idx_ok;

  assign scl      = (scale_r == 4'd0) ? 4'd1 : scale_r;
  assign scl_last = scl - 4'd1;
  assign col_bits = glyph_col(code_r, gc_r);
  assign gbit     = col_bits[gr_r];

  assign cur_x    = glyph_r ? cb_r + 10'(sx_r) : lx_r + (vert_r ? 10'd0 : 10'(cnt_r));
  assign cur_y    = glyph_r ? rb_r + 10'(sy_r) : ly_r + (vert_r ? 10'(cnt_r) : 10'd0);
  assign in_frame = (cur_x < W10) && (cur_y < H10);
  assign along    = vert_r ? cur_y : cur_x;
  assign limit    = vert_r ? H10 : W10;

  // byte = column + page * width
  assign pix_addr = AW'(cur_x) + AW'(32'(cur_y[9:3]) * FRAME_WIDTH);
  assign mask     = 8'd1 << cur_y[2:0];

  always_comb begin
    if (ink_r == INK_SET)       pix_wdata = rdata | mask;
    else if (ink_r == INK_FLIP) pix_wdata = rdata ^ mask;
    else                        pix_wdata = rdata & ~mask;
    if (ink_r == INK_SET)       fill_wdata = 8'hFF;
    else if (ink_r == INK_FLIP) fill_wdata = ~rdata;
    else                        fill_wdata = 8'h00;
  end

  // rectangle clipped to the frame
  assign wlim   = W10 - {2'b00, x_r};
  assign hlim   = H10 - {3'b000, y_r};
  assign wc     = ({2'b00, run_r} > wlim) ? wlim : {2'b00, run_r};
  assign hc     = ({3'b000, hgt_r} > hlim) ? hlim : {3'b000, hgt_r};
  assign idx_ok = {3'b000, idx_r} < 13'(STORE_BYTES);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 8'h00;
    ram_addr  = pix_addr;
    unique case (cmd.op)
      OP_CLR_WR: begin
        ram_we   = 1'b1;
        ram_addr = sweep_r;
      end
      OP_FILL_RD: begin
        ram_addr = sweep_r;
      end
      OP_FILL_WR: begin
        ram_we    = 1'b1;
        ram_addr  = sweep_r;
        ram_wdata = fill_wdata;
      end
      OP_PIX_WR: begin
        ram_we    = 1'b1;
        ram_wdata = pix_wdata;
      end
      OP_BYTE_RD: begin
        ram_addr = AW'(idx_r);
      end
      default: begin
        ram_addr = pix_addr;
      end
    endcase
  end

  fbde_ram #(
    .DATA_W (8),
    .DEPTH  (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mode_r  <= in_tdata[3:0];
      x_r     <= in_tdata[11:4];
      y_r     <= in_tdata[18:12];
      run_r   <= in_tdata[26:19];
      hgt_r   <= in_tdata[33:27];
      ink_r   <= in_tdata[35:34];
      code_r  <= in_tdata[43:36];
      scale_r <= in_tdata[47:44];
      idx_r   <= in_tdata[57:48];
    end
  end

  // position walker
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SEG_SET) begin
      glyph_r <= 1'b0;
      cnt_r   <= 8'd0;
      lx_r    <= {2'b00, x_r};
      ly_r    <= {3'b000, y_r};
      unique case (cmd.seg)
        SEG_DOT: begin
          vert_r <= 1'b0;
          len_r  <= 8'd1;
        end
        SEG_HORZ: begin
          vert_r <= 1'b0;
          len_r  <= run_r;
        end
        SEG_VERT: begin
          vert_r <= 1'b1;
          len_r  <= run_r;
        end
        SEG_TOP: begin
          vert_r <= 1'b0;
          len_r  <= wc[7:0];
        end
        SEG_BOTTOM: begin
          vert_r <= 1'b0;
          len_r  <= wc[7:0];
          ly_r   <= {3'b000, y_r} + hc - 10'd1;
        end
        SEG_LEFT: begin
          vert_r <= 1'b1;
          len_r  <= hc[7:0];
        end
        SEG_RIGHT: begin
          vert_r <= 1'b1;
          len_r  <= hc[7:0];
          lx_r   <= {2'b00, x_r} + wc - 10'd1;
        end
        default: begin
          vert_r <= 1'b0;
          len_r  <= 8'd0;
        end
      endcase
    end else if (cmd.op == OP_GLYPH_INIT) begin
      glyph_r <= 1'b1;
      gc_r    <= 3'd0;
      gr_r    <= 3'd0;
      sx_r    <= 4'd0;
      sy_r    <= 4'd0;
      cb_r    <= {2'b00, x_r};
      rb_r    <= {3'b000, y_r};
    end else if (cmd.op == OP_ADVANCE || cmd.op == OP_PIX_WR) begin
      if (!glyph_r) begin
        cnt_r <= cnt_r + 8'd1;
      end else if (gbit && !(sx_r == scl_last && sy_r == scl_last)) begin
        // next sub-pixel of a set font bit, rows inner
        if (sy_r == scl_last) begin
          sy_r <= 4'd0;
          sx_r <= sx_r + 4'd1;
        end else begin
          sy_r <= sy_r + 4'd1;
        end
      end else begin
        // next font bit; clear bits are skipped whole
        sx_r <= 4'd0;
        sy_r <= 4'd0;
        if (gr_r == 3'(GLYPH_ROWS - 1)) begin
          gr_r <= 3'd0;
          gc_r <= gc_r + 3'd1;
          cb_r <= cb_r + 10'(scl);
          rb_r <= {3'b000, y_r};
        end else begin
          gr_r <= gr_r + 3'd1;
          rb_r <= rb_r + 10'(scl);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      dirty_r <= 1'b0;
    end else begin
      if (cmd.op == OP_CLR_WR || cmd.op == OP_FILL_WR) begin
        sweep_r <= (sweep_r == SWEEP_END) ? '0 : sweep_r + AW'(1);
      end
      if (cmd.op == OP_FILL_WR || cmd.op == OP_PIX_WR) begin
        dirty_r <= 1'b1;
      end else if (cmd.op == OP_CLR_DIRTY) begin
        dirty_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      res_pix_r  <= 1'b0;
      res_byte_r <= 8'h00;
    end else if (cmd.op == OP_SAMPLE_PIX) begin
      res_pix_r <= in_frame & rdata[cur_y[2:0]];
    end else if (cmd.op == OP_SAMPLE_BYTE) begin
      res_byte_r <= idx_ok ? rdata : 8'h00;
    end
    if (cmd.op == OP_RESULT) begin
      out_pix_r   <= res_pix_r;
      out_byte_r  <= res_byte_r;
      out_dirty_r <= dirty_r;
    end
  end

  always_comb begin
    status.mode       = mode_r;
    status.more       = glyph_r ? (gc_r != 3'(GLYPH_COLS))
                                : ((cnt_r < len_r) && (along < limit));
    status.live       = glyph_r ? (gbit & in_frame) : in_frame;
    status.box_ok     = (x_r < W10[7:0] || FRAME_WIDTH == 256) && ({3'b000, y_r} < H10)
                        && (run_r != 8'd0) && (hgt_r != 7'd0);
    status.origin_ok  = ({2'b00, x_r} < W10) && ({3'b000, y_r} < H10);
    status.sweep_last = (sweep_r == SWEEP_END);
  end

  assign out_tdata = {6'b000000, out_dirty_r, out_byte_r, out_pix_r};

endmodule

// ----- src/fbde_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbde_ctrl: command sequencer
// Runs the post-reset clearing pass, decodes each command and steps the
// datapath through it; owns the input ready and the result valid.
// ----------------------------------------------------------------------------
module fbde_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  fbde_pkg::status_t status,
  output fbde_pkg::cmd_t    cmd
);
  import fbde_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_WRITE,
    S_PIX_RD,
    S_PIX_SAMP,
    S_FILL_RD,
    S_FILL_WR,
    S_BYTE_SAMP,
    S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = OP_NOP;
    cmd.seg       = SEG_DOT;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLR_WR;
        if (status.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        seg_nxt = 2'd0;
        unique case (status.mode)
          MODE_PIXEL: begin
            cmd.op    = OP_SEG_SET;
            state_nxt = S_WALK;
          end
          MODE_READ_PIXEL: begin
            cmd.op    = OP_SEG_SET;
            state_nxt = S_PIX_RD;
          end
          MODE_FILL: begin
            state_nxt = S_FILL_RD;
          end
          MODE_HLINE: begin
            cmd.op    = OP_SEG_SET;
            cmd.seg   = SEG_HORZ;
            state_nxt = S_WALK;
          end
          MODE_VLINE: begin
            cmd.op    = OP_SEG_SET;
            cmd.seg   = SEG_VERT;
            state_nxt = S_WALK;
          end
          MODE_RECT: begin
            if (status.box_ok) begin
              cmd.op    = OP_SEG_SET;
              cmd.seg   = SEG_TOP;
              state_nxt = S_WALK;
            end else begin
              state_nxt = S_FINISH;
            end
          end
          MODE_GLYPH: begin
            if (status.origin_ok) begin
              cmd.op    = OP_GLYPH_INIT;
              state_nxt = S_WALK;
            end else begin
              state_nxt = S_FINISH;
            end
          end
          MODE_READ_BYTE: begin
            cmd.op    = OP_BYTE_RD;
            state_nxt = S_BYTE_SAMP;
          end
          MODE_CLR_DIRTY: begin
            cmd.op    = OP_CLR_DIRTY;
            state_nxt = S_FINISH;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_WALK: begin
        if (status.more) begin
          if (status.live) begin
            cmd.op    = OP_PIX_RD;
            state_nxt = S_WRITE;
          end else begin
            cmd.op = OP_ADVANCE;
          end
        end else if (status.mode == MODE_RECT && seg_r != 2'd3) begin
          // rectangle: top, bottom, left, right in turn
          cmd.op  = OP_SEG_SET;
          seg_nxt = seg_r + 2'd1;
          unique case (seg_r)
            2'd0:    cmd.seg = SEG_BOTTOM;
            2'd1:    cmd.seg = SEG_LEFT;
            default: cmd.seg = SEG_RIGHT;
          endcase
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_WRITE: begin
        cmd.op    = OP_PIX_WR;
        state_nxt = S_WALK;
      end
      S_PIX_RD: begin
        cmd.op    = OP_PIX_RD;
        state_nxt = S_PIX_SAMP;
      end
      S_PIX_SAMP: begin
        cmd.op    = OP_SAMPLE_PIX;
        state_nxt = S_FINISH;
      end
      S_FILL_RD: begin
        cmd.op    = OP_FILL_RD;
        state_nxt = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.op    = OP_FILL_WR;
        state_nxt = status.sweep_last ? S_FINISH : S_FILL_RD;
      end
      S_BYTE_SAMP: begin
        cmd.op    = OP_SAMPLE_BYTE;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      seg_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ----- src/mono_framebuffer_draw_engine.sv -----
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine: page-organized monochrome frame store drawer
// Each drawn pixel of a line, rectangle or glyph is read, then written back;
// positions off the frame and clear font bits are skipped without a store
// write; a fill reads and rewrites every store byte in turn.
// Throughput: one command at a time, bound by the single-port store.
// Reset: a clearing pass writes zero to every one of the FRAME_WIDTH *
// ceil(FRAME_HEIGHT/8) store bytes (1024 by default); no command is taken meanwhile.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine #(
  parameter int FRAME_WIDTH  = fbde_pkg::FRAME_WIDTH_DEF,   // 8..256
  parameter int FRAME_HEIGHT = fbde_pkg::FRAME_HEIGHT_DEF   // 8..128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // command beat
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [3:0] mode, [11:4] x_pos, [18:12] y_pos, [26:19] run_length,
  // [33:27] box_height, [35:34] ink, [43:36] char_code, [47:44] glyph_scale,
  // [57:48] byte_index, [63:58] zero
  input  logic [fbde_pkg::IN_DATA_W-1:0]   in_tdata,
  // result beat
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] pixel_bit, [8:1] frame_byte, [9] dirty_now, [15:10] zero
  output logic [fbde_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import fbde_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: decodes the command, walks positions, owns handshakes
  fbde_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // store, walker and result registers
  fbde_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

  // a taken command keeps the port closed while it runs
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("command port open right after a beat");

  // every store write of a pixel follows the read of that byte
  a_rmw_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PIX_WR) |-> ($past(cmd.op) == OP_PIX_RD))
    else $error("pixel write without preceding read");

  // nothing touches the store while waiting for a command
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (cmd.op == OP_NOP || cmd.op == OP_LOAD))
    else $error("datapath busy while idle");

  // a result is only raised by the finishing step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(cmd.op) == OP_RESULT))
    else $error("result valid without result step");

endmodule

// ----- dv/mono_framebuffer_draw_engine_tb.sv -----
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_tb: self-checking bench for the draw engine
// Drives directed and random drawing/read commands over the input stream,
// tracks a shadow copy of the frame store and dirty mark, and compares every
// result beat field by field. Both sides idle at random; the receiver also
// holds off for a long stretch and the sender pauses to drain now and then.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine_tb;
  import fbde_pkg::*;

  localparam int FW          = 128;
  localparam int FH          = 64;
  localparam int STORE_LEN   = FW * ((FH + 7) / 8);
  localparam int STALL_LIMIT = 80000;  // covers the worst glyph (scale 15)
  localparam int LONG_HOLD   = 400;

  typedef struct {
    logic [IN_DATA_W-1:0] data;
    bit                   drain;    // wait for every result before offering
    bit                   no_gap;   // back-to-back with the previous beat
  } cmd_item_t;

  typedef struct packed {
    logic       dirty;
    logic [7:0] byte_val;
    logic       pix;
  } result_t;

  // 5x7 font, column-coded, LSB on top
  localparam logic [7:0] DIGITS [10][5] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E}
  };
  localparam logic [7:0] LETTERS [26][5] = '{
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };
  localparam logic [7:0] SHAPE_QUERY [5] = '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
  localparam logic [7:0] SHAPE_MINUS [5] = '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
  localparam logic [7:0] SHAPE_DOT   [5] = '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
  localparam logic [7:0] SHAPE_COLON [5] = '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
  localparam logic [7:0] SHAPE_SLASH [5] = '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  mono_framebuffer_draw_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the engine state
  logic [7:0] shadow_store [STORE_LEN];
  logic       shadow_dirty;

  cmd_item_t pending_cmds [$];
  result_t   expected_results [$];
  int        errors = 0;
  int        idle_cycles = 0;

  // ---- shadow model -------------------------------------------------------
  function automatic logic [7:0] glyph_column(input logic [7:0] code, input int col);
    logic [7:0] c;
    c = code;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    if (c >= "0" && c <= "9") return DIGITS[c - 8'd48][col];
    if (c >= "A" && c <= "Z") return LETTERS[c - 8'd65][col];
    case (c)
      " ":     return 8'h00;
      "-":     return SHAPE_MINUS[col];
      ".":     return SHAPE_DOT[col];
      ":":     return SHAPE_COLON[col];
      "/":     return SHAPE_SLASH[col];
      default: return SHAPE_QUERY[col];
    endcase
  endfunction

  function automatic void plot(input int x, input int y, input logic [1:0] ink);
    int at;
    if (x >= FW || y >= FH) return;
    at = x + (y / 8) * FW;
    if (ink == INK_SET)       shadow_store[at][y % 8] = 1'b1;
    else if (ink == INK_FLIP) shadow_store[at][y % 8] = ~shadow_store[at][y % 8];
    else                      shadow_store[at][y % 8] = 1'b0;
    shadow_dirty = 1'b1;
  endfunction

  function automatic void run_h(input int x, input int y, input int len, input logic [1:0] ink);
    for (int k = 0; k < len && x + k < FW; k++) plot(x + k, y, ink);
  endfunction

  function automatic void run_v(input int x, input int y, input int len, input logic [1:0] ink);
    for (int k = 0; k < len && y + k < FH; k++) plot(x, y + k, ink);
  endfunction

  // applies one accepted command and queues the result it must produce
  function automatic void execute_command(input logic [IN_DATA_W-1:0] d);
    logic [3:0] mode;
    logic [1:0] ink;
    logic [7:0] gcol;
    int x, y, len, h, scale, idx;
    result_t r;
    mode  = d[3:0];
    x     = d[11:4];
    y     = d[18:12];
    len   = d[26:19];
    h     = d[33:27];
    ink   = d[35:34];
    scale = d[47:44];
    idx   = d[57:48];
    r     = '0;
    case (mode)
      MODE_PIXEL:      plot(x, y, ink);
      MODE_READ_PIXEL: if (x < FW && y < FH) r.pix = shadow_store[x + (y / 8) * FW][y % 8];
      MODE_FILL: begin
        for (int k = 0; k < STORE_LEN; k++)
          shadow_store[k] = (ink == INK_FLIP) ? ~shadow_store[k] :
                            (ink == INK_SET) ? 8'hFF : 8'h00;
        shadow_dirty = 1'b1;
      end
      MODE_HLINE:      run_h(x, y, len, ink);
      MODE_VLINE:      run_v(x, y, len, ink);
      MODE_RECT: begin
        if (x < FW && y < FH && len != 0 && h != 0) begin
          if (len > FW - x) len = FW - x;
          if (h > FH - y) h = FH - y;
          // four separate lines: flipped corners toggle twice
          run_h(x, y, len, ink);
          run_h(x, y + h - 1, len, ink);
          run_v(x, y, h, ink);
          run_v(x + len - 1, y, h, ink);
        end
      end
      MODE_GLYPH: begin
        if (x < FW && y < FH) begin
          if (scale == 0) scale = 1;
          for (int c = 0; c < 5; c++) begin
            gcol = glyph_column(d[43:36], c);
            for (int rr = 0; rr < 7; rr++)
              if (gcol[rr])
                for (int sx = 0; sx < scale; sx++)
                  for (int sy = 0; sy < scale; sy++)
                    plot(x + c * scale + sx, y + rr * scale + sy, ink);
          end
        end
      end
      MODE_READ_BYTE:  if (idx < STORE_LEN) r.byte_val = shadow_store[idx];
      MODE_CLR_DIRTY:  shadow_dirty = 1'b0;
      default: ;  // unused codes do nothing
    endcase
    r.dirty = shadow_dirty;
    expected_results.push_back(r);
  endfunction

  // ---- command building ---------------------------------------------------
  function automatic logic [IN_DATA_W-1:0] pack_cmd(
      input logic [3:0] mode, input logic [7:0] x, input logic [6:0] y,
      input logic [7:0] len, input logic [6:0] h, input logic [1:0] ink,
      input logic [7:0] code, input logic [3:0] scale, input logic [9:0] idx);
    return {6'd0, idx, scale, code, ink, h, len, y, x, mode};
  endfunction

  task automatic queue_cmd(input logic [IN_DATA_W-1:0] d, input bit drain, input bit no_gap);
    cmd_item_t it;
    it.data   = d;
    it.drain  = drain;
    it.no_gap = no_gap;
    pending_cmds.push_back(it);
  endtask

  function automatic logic [IN_DATA_W-1:0] random_cmd();
    logic [3:0] mode;
    logic [7:0] x, len, code;
    logic [6:0] y, h;
    logic [3:0] scale;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 14)      mode = MODE_PIXEL;
    else if (pick < 30) mode = MODE_READ_PIXEL;
    else if (pick < 32) mode = MODE_FILL;
    else if (pick < 42) mode = MODE_HLINE;
    else if (pick < 52) mode = MODE_VLINE;
    else if (pick < 62) mode = MODE_RECT;
    else if (pick < 72) mode = MODE_GLYPH;
    else if (pick < 92) mode = MODE_READ_BYTE;
    else if (pick < 96) mode = MODE_CLR_DIRTY;
    else                mode = 4'($urandom_range(9, 15));
    // mostly on or near the frame, sometimes anywhere
    x    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, FW + 8));
    y    = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, FH + 4));
    len  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
    h    = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 24));
    code = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7A));
    scale = ($urandom_range(0, 59) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 3));
    return pack_cmd(mode, x, y, len, h, 2'($urandom), code, scale, 10'($urandom));
  endfunction

  // ---- driver -------------------------------------------------------------
  int        send_gap = 0;
  cmd_item_t next_cmd;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) execute_command(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain &&
                       (expected_results.size() > 0 || (in_tvalid && in_tready)))) begin
          next_cmd  = pending_cmds.pop_front();
          in_tdata  <= next_cmd.data;
          in_tvalid <= 1'b1;
          send_gap  <= (pending_cmds.size() > 0 && pending_cmds[0].no_gap) ? 0 :
                       $urandom_range(0, 8);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor and receiver -----------------------------------------------
  int      recv_wait = 0;
  int      results_seen = 0;
  result_t got, want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[9:0];
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.pix !== want.pix) begin
            $display("%0t: pixel_bit exp %0d got %0d", $time, want.pix, got.pix);
            errors++;
          end
          if (got.byte_val !== want.byte_val) begin
            $display("%0t: frame_byte exp %h got %h", $time, want.byte_val, got.byte_val);
            errors++;
          end
          if (got.dirty !== want.dirty) begin
            $display("%0t: dirty_now exp %0d got %0d", $time, want.dirty, got.dirty);
            errors++;
          end
        end
        // long hold-off once, short random waits otherwise; every 300 beats
        // the receiver runs without stalls for a while
        if (results_seen == 200)            recv_wait = LONG_HOLD;
        else if ((results_seen / 100) % 3 == 2) recv_wait = 0;
        else                                recv_wait = $urandom_range(0, 8);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---- watchdog -----------------------------------------------------------
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("mono_framebuffer_draw_engine: mismatch");
      $finish;
    end
  end

  // ---- stimulus and end of run --------------------------------------------
  initial begin
    for (int k = 0; k < STORE_LEN; k++) shadow_store[k] = 8'h00;
    shadow_dirty = 1'b0;

    // directed: extremes, every mode, off-screen, fonts, corner toggling
    queue_cmd(pack_cmd(MODE_READ_BYTE, 0, 0, 0, 0, 0, 0, 0, 10'd1023), 0, 0);
    queue_cmd(pack_cmd(MODE_PIXEL, 0, 0, 0, 0, INK_SET, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_PIXEL, 8'd127, 7'd63, 0, 0, INK_SET, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_READ_PIXEL, 8'd127, 7'd63, 0, 0, 0, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_CLR_DIRTY, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_PIXEL, 8'd255, 7'd127, 0, 0, INK_SET, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_READ_PIXEL, 8'd128, 7'd0, 0, 0, 0, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_PIXEL, 0, 0, 0, 0, 2'd3, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_HLINE, 8'd120, 7'd5, 8'd255, 0, INK_SET, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_VLINE, 8'd3, 7'd60, 8'd255, 0, INK_FLIP, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_HLINE, 8'd10, 7'd10, 8'd0, 0, INK_SET, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_RECT, 8'd20, 7'd20, 8'd10, 7'd1, INK_FLIP, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_RECT, 8'd100, 7'd40, 8'd255, 7'd127, INK_FLIP, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_RECT, 8'd128, 7'd0, 8'd5, 7'd5, INK_SET, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_RECT, 8'd5, 7'd5, 8'd0, 7'd5, INK_SET, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_GLYPH, 8'd0, 7'd0, 0, 0, INK_SET, "a", 4'd0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_GLYPH, 8'd6, 7'd0, 0, 0, INK_FLIP, "Z", 4'd2, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_GLYPH, 8'd124, 7'd60, 0, 0, INK_SET, "0", 4'd1, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_GLYPH, 8'd30, 7'd30, 0, 0, INK_SET, 8'hFF, 4'd15, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_GLYPH, 8'd50, 7'd8, 0, 0, INK_FLIP, "/", 4'd1, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_GLYPH, 8'd60, 7'd8, 0, 0, 2'd3, ":", 4'd3, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_GLYPH, 8'd200, 7'd8, 0, 0, INK_SET, "-", 4'd1, 0), 0, 0);
    queue_cmd(pack_cmd(4'd15, 8'd1, 7'd1, 0, 0, INK_SET, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_FILL, 0, 0, 0, 0, INK_FLIP, 0, 0, 0), 0, 0);
    queue_cmd(pack_cmd(MODE_FILL, 0, 0, 0, 0, 2'd3, 0, 0, 0), 1, 0);

    // random: drain pauses now and then, some no-gap stretches
    for (int n = 0; n < 1430; n++) begin
      if (n == 500) queue_cmd(pack_cmd(MODE_FILL, 0, 0, 0, 0, INK_SET, 0, 0, 0), 0, 1);
      queue_cmd(random_cmd(), (n % 250) == 249, (n / 50) % 4 == 1);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_cmds.size() == 0 && !in_tvalid && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("mono_framebuffer_draw_engine: match");
    end else begin
      $display("mono_framebuffer_draw_engine: mismatch");
    end
    $finish;
  end

endmodule
